@@ hdl/epoch_seconds_to_calendar_core_assert.svh @@
// assertion macros for the checker file
// no dependencies; include by bare file name
`ifndef EPOCH_SECONDS_TO_CALENDAR_CORE_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_CORE_ASSERT_SVH

// same-cycle implication, off while reset is held
`define ESC_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define ESC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/esc_pkg.sv @@
// shared types, constants and the month table for the epoch to calendar core
// no dependencies
`default_nettype none

package esc_pkg;

    // reciprocal constants for the constant divisions (exact over the value range)
    // days = (t >> 7) / 675, 25-bit operand
    localparam logic [25:0] DAY_RECIP   = 26'd50903317;
    localparam int          DAY_SHIFT   = 35;
    localparam logic [9:0]  DAY_DIV128  = 10'd675;
    // hour = (sod >> 4) / 225, 13-bit operand
    localparam logic [13:0] HOUR_RECIP  = 14'd9321;
    localparam int          HOUR_SHIFT  = 21;
    // minute of day = (sod >> 2) / 15, 15-bit operand
    localparam logic [15:0] MIN_RECIP   = 16'd34953;
    localparam int          MIN_SHIFT   = 19;
    // four-year cycles = d / 1461, 16-bit operand
    localparam logic [16:0] CYCLE_RECIP = 17'd91868;
    localparam int          CYCLE_SHIFT = 27;
    localparam logic [10:0] CYCLE_DAYS  = 11'd1461;

    // calendar anchors
    localparam logic [15:0] EPOCH_OFFSET    = 16'd731;   // days from 1968-01-01 to 1970-01-01
    localparam logic [15:0] CENTURY_MAR_1ST = 16'd47541; // day index of 2100-03-01
    localparam logic [11:0] CYCLE_BASE_YEAR = 12'd1968;
    localparam logic [10:0] YEAR1_START     = 11'd366;
    localparam logic [10:0] YEAR2_START     = 11'd731;
    localparam logic [10:0] YEAR3_START     = 11'd1096;

    // first day of each month in a common year (lengths 31 28 31 30 31 30 31 31 30 31 30 31)
    localparam logic [8:0] MONTH_START [12] = '{
        9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    // time of day result
    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } tod_t;

    // date result
    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
    } date_t;

    // first day of year of a month, february has 29 days in a leap year
    function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
        logic [8:0] base;
        base = 9'd0;
        if (m < 4'd12) begin
            base = MONTH_START[m];
        end
        if (leap && (m >= 4'd2) && (m < 4'd12)) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

`default_nettype wire

@@ hdl/esc_tod.sv @@
// time-of-day path: seconds of day, then hour, minute and second
// depends on esc_pkg
`default_nettype none

module esc_tod (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [31:0] t_s1,
    input  wire logic [15:0] days_s1,
    output esc_pkg::tod_t    tod_s4
);
    import esc_pkg::*;

    logic [24:0] day_base;
    logic [24:0] rem128;
    logic [16:0] sod_next;
    logic [16:0] sod2_reg;
    logic [26:0] hour_prod;
    logic [30:0] mod_prod;
    logic [4:0]  hour3_reg;
    logic [10:0] mod3_reg;
    logic [16:0] sod3_reg;
    logic [16:0] mod_secs;
    logic [16:0] sec_full;
    logic [10:0] hour_mins;
    logic [10:0] min_full;
    tod_t        tod4_reg;

    // seconds of day from the low bits and what is left after whole days
    assign day_base = {9'd0, days_s1} * {15'd0, DAY_DIV128};
    assign rem128   = t_s1[31:7] - day_base;
    assign sod_next = {rem128[9:0], t_s1[6:0]};

    // hour and minute of day by reciprocal multiply
    assign hour_prod = sod2_reg[16:4] * HOUR_RECIP;
    assign mod_prod  = sod2_reg[16:2] * MIN_RECIP;

    // remainders
    assign mod_secs  = {6'd0, mod3_reg} * 17'd60;
    assign sec_full  = sod3_reg - mod_secs;
    assign hour_mins = {6'd0, hour3_reg} * 11'd60;
    assign min_full  = mod3_reg - hour_mins;

    // pipeline registers
    always_ff @(posedge aclk) begin
        if (en) begin
            sod2_reg         <= sod_next;
            hour3_reg        <= hour_prod[HOUR_SHIFT+4:HOUR_SHIFT];
            mod3_reg         <= mod_prod[MIN_SHIFT+10:MIN_SHIFT];
            sod3_reg         <= sod2_reg;
            tod4_reg.hour    <= hour3_reg;
            tod4_reg.minute  <= min_full[5:0];
            tod4_reg.second  <= sec_full[5:0];
        end
    end

    assign tod_s4 = tod4_reg;

endmodule

`default_nettype wire

@@ hdl/esc_date.sv @@
// date path: day count to year, month and day of month
// depends on esc_pkg
`default_nettype none

module esc_date (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [15:0] days_s1,
    output esc_pkg::date_t   date_s4
);
    import esc_pkg::*;

    logic [15:0] d2_next;
    logic [15:0] d2_reg;
    logic [32:0] cyc_prod;
    logic [5:0]  cyc3_reg;
    logic [15:0] d3_reg;
    logic [15:0] cyc_days;
    logic [15:0] r_full;
    logic [10:0] r4_reg;
    logic [5:0]  cyc4_reg;
    logic [1:0]  year_idx;
    logic [10:0] year_off;
    logic [8:0]  doy;
    logic        leap;
    logic [3:0]  month;
    logic [8:0]  day_zero;

    // days since 1968-01-01, a phantom feb 29 of 2100 keeps a plain four-year cycle
    always_comb begin
        d2_next = days_s1 + EPOCH_OFFSET;
        if (days_s1 >= CENTURY_MAR_1ST) begin
            d2_next = d2_next + 16'd1;
        end
    end

    // four-year cycle number and the day within the cycle
    assign cyc_prod = d2_reg * CYCLE_RECIP;
    assign cyc_days = {10'd0, cyc3_reg} * {5'd0, CYCLE_DAYS};
    assign r_full   = d3_reg - cyc_days;

    // pipeline registers
    always_ff @(posedge aclk) begin
        if (en) begin
            d2_reg   <= d2_next;
            cyc3_reg <= cyc_prod[CYCLE_SHIFT+5:CYCLE_SHIFT];
            d3_reg   <= d2_reg;
            r4_reg   <= r_full[10:0];
            cyc4_reg <= cyc3_reg;
        end
    end

    // year within the cycle, the first year is the leap year
    always_comb begin
        priority if (r4_reg < YEAR1_START) begin
            year_idx = 2'd0;
            year_off = 11'd0;
        end else if (r4_reg < YEAR2_START) begin
            year_idx = 2'd1;
            year_off = YEAR1_START;
        end else if (r4_reg < YEAR3_START) begin
            year_idx = 2'd2;
            year_off = YEAR2_START;
        end else begin
            year_idx = 2'd3;
            year_off = YEAR3_START;
        end
    end

    assign doy  = 9'(r4_reg - year_off);
    assign leap = (year_idx == 2'd0);

    // month search over the start table, later months win
    always_comb begin
        month = 4'd0;
        for (int m = 1; m < 12; m++) begin
            if (doy >= month_start(4'(m), leap)) begin
                month = 4'(m);
            end
        end
    end

    assign day_zero = doy - month_start(month, leap);

    assign date_s4.year         = CYCLE_BASE_YEAR + {4'd0, cyc4_reg, 2'd0} + {10'd0, year_idx};
    assign date_s4.month        = month;
    assign date_s4.day_of_month = 5'(day_zero + 9'd1);

endmodule

`default_nettype wire

@@ hdl/epoch_seconds_to_calendar_core.sv @@
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 into
// second, minute, hour, day of month (1..31), month (0..11) and full year on the
// proleptic Gregorian calendar (2100 is a common year). One request is taken every
// clock cycle while the result side keeps up. The rate is set by a single stall
// enable shared by the input register, four pipeline stages of constant reciprocal
// multiplies and the output register: when a result waits, the whole pipe holds.
// There is no state beyond the pipeline itself.
// depends on esc_pkg, esc_tod, esc_date
`default_nettype none

module epoch_seconds_to_calendar_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output wire logic        s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] epoch_seconds
    output wire logic        m_tvalid,
    input  wire logic        m_tready,
    output wire logic [39:0] m_tdata    // [5:0] second, [11:6] minute, [16:12] hour,
                                        // [21:17] day_of_month, [25:22] month,
                                        // [37:26] year, [39:38] zero
);
    import esc_pkg::*;

    logic        advance;
    logic [4:0]  valid_reg;
    logic        m_valid_reg;
    logic [31:0] t0_reg;
    logic [31:0] t1_reg;
    logic [50:0] day_prod;
    logic [15:0] days1_reg;
    tod_t        tod_s4;
    date_t       date_s4;
    logic [39:0] m_data_reg;

    // the whole pipe moves unless a finished result is still waiting
    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = advance;

    // whole days by reciprocal multiply
    assign day_prod = t0_reg[31:7] * DAY_RECIP;

    // stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg   <= {valid_reg[3:0], s_tvalid};
            m_valid_reg <= valid_reg[4];
        end
    end

    // input, day count and result registers
    always_ff @(posedge aclk) begin
        if (advance) begin
            t0_reg     <= s_tdata;
            t1_reg     <= t0_reg;
            days1_reg  <= day_prod[DAY_SHIFT+15:DAY_SHIFT];
            m_data_reg <= {2'b00, date_s4.year, date_s4.month, date_s4.day_of_month,
                           tod_s4.hour, tod_s4.minute, tod_s4.second};
        end
    end

    esc_tod u_tod (
        .aclk    (aclk),
        .en      (advance),
        .t_s1    (t1_reg),
        .days_s1 (days1_reg),
        .tod_s4  (tod_s4)
    );

    esc_date u_date (
        .aclk    (aclk),
        .en      (advance),
        .days_s1 (days1_reg),
        .date_s4 (date_s4)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

@@ hdl/esc_checker.sv @@
// port-level checks for the epoch to calendar core, bound to the top level
// depends on epoch_seconds_to_calendar_core_assert.svh
`default_nettype none

`include "epoch_seconds_to_calendar_core_assert.svh"

module esc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata
);

    // a stalled result holds its value
    `ESC_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

    // requests are taken exactly when the result register can move
    `ESC_ASSERT_IMPLY(a_ready_follows_output, aclk, aresetn, 1'b1, s_tready == (!m_tvalid || m_tready), "input ready does not track the output side")

    // time of day fields in range
    `ESC_ASSERT_IMPLY(a_time_range, aclk, aresetn, m_tvalid, (m_tdata[5:0] < 6'd60) && (m_tdata[11:6] < 6'd60) && (m_tdata[16:12] < 5'd24), "time of day field out of range")

    // date fields in range and padding clear
    `ESC_ASSERT_IMPLY(a_date_range, aclk, aresetn, m_tvalid, (m_tdata[21:17] != 5'd0) && (m_tdata[25:22] < 4'd12) && (m_tdata[37:26] >= 12'd1970) && (m_tdata[37:26] <= 12'd2106) && (m_tdata[39:38] == 2'd0), "date field out of range")

endmodule

bind epoch_seconds_to_calendar_core esc_checker u_checker (.*);

`default_nettype wire

@@ tb/tb_epoch_seconds_to_calendar_core.sv @@
// testbench for epoch_seconds_to_calendar_core: streams epoch second counts in and
// checks every calendar result against a predictor with random idling and stalls
// depends only on the core and its package
`timescale 1ns / 1ps

// one calendar result, laid out as m_tdata carries it
typedef struct packed {
    logic [1:0]  pad;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
} calendar_t;

// a request and the calendar it should turn into
typedef struct packed {
    logic [31:0] secs;
    calendar_t   cal;
} conversion_t;

// gregorian rule: century years are leap only every fourth century
function automatic bit leap_year(input int unsigned yr);
    return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
endfunction

function automatic int unsigned month_length(input int unsigned mo, input int unsigned yr);
    case (mo)
        1: begin
            return leap_year(yr) ? 29 : 28;
        end
        3, 5, 8, 10: begin
            return 30;
        end
        default: begin
            return 31;
        end
    endcase
endfunction

// seconds since 1970-01-01 00:00:00 to calendar date and time of day
function automatic calendar_t to_calendar(input logic [31:0] secs);
    int unsigned total;
    int unsigned day_count;
    int unsigned yr;
    int unsigned mo;
    int unsigned span;
    calendar_t c;
    total = secs;
    c = '0;
    c.second = 6'(total % 60);
    c.minute = 6'((total / 60) % 60);
    c.hour = 5'((total / 3600) % 24);
    day_count = total / 86400;
    // walk whole years, then whole months
    yr = 1970;
    span = leap_year(yr) ? 366 : 365;
    while (day_count >= span) begin
        day_count -= span;
        yr++;
        span = leap_year(yr) ? 366 : 365;
    end
    mo = 0;
    span = month_length(mo, yr);
    while (mo < 11 && day_count >= span) begin
        day_count -= span;
        mo++;
        span = month_length(mo, yr);
    end
    c.day_of_month = 5'(day_count + 1);
    c.month = 4'(mo);
    c.year = 12'(yr);
    return c;
endfunction

// holds expected calendars in request order and checks results against them
class calendar_scoreboard;
    conversion_t awaited[$];
    int errors;

    function new();
        errors = 0;
    endfunction

    task report(input string what);
        $display("%0t ns mismatch: %s", $time, what);
        errors++;
    endtask

    function void note_request(input logic [31:0] secs);
        conversion_t entry;
        entry.secs = secs;
        entry.cal = to_calendar(secs);
        awaited.push_back(entry);
    endfunction

    function int pending();
        return awaited.size();
    endfunction

    task compare_field(input string field, input logic [31:0] secs,
                       input int unsigned got, input int unsigned want);
        if (got != want) begin
            report($sformatf("request %0d: %s is %0d, expected %0d", secs, field, got, want));
        end
    endtask

    task check_result(input logic [39:0] data);
        calendar_t got;
        conversion_t want;
        if (awaited.size() == 0) begin
            report($sformatf("result %h with no request outstanding", data));
            return;
        end
        got = data;
        want = awaited.pop_front();
        compare_field("second", want.secs, got.second, want.cal.second);
        compare_field("minute", want.secs, got.minute, want.cal.minute);
        compare_field("hour", want.secs, got.hour, want.cal.hour);
        compare_field("day_of_month", want.secs, got.day_of_month, want.cal.day_of_month);
        compare_field("month", want.secs, got.month, want.cal.month);
        compare_field("year", want.secs, got.year, want.cal.year);
        compare_field("pad bits", want.secs, got.pad, want.cal.pad);
    endtask

    task flush_check();
        if (awaited.size() != 0) begin
            report($sformatf("%0d results never arrived", awaited.size()));
        end
    endtask
endclass

module tb_epoch_seconds_to_calendar_core;

    // boundaries: epoch, unit rollovers, leap days, century year, bit patterns
    localparam int CORNER_COUNT = 24;
    localparam logic [31:0] CORNER_SECS [CORNER_COUNT] = '{
        32'd0,          32'hFFFF_FFFF,  32'd59,         32'd60,
        32'd3599,       32'd3600,       32'd86399,      32'd86400,
        32'd2678399,    32'd2678400,    32'd31535999,   32'd31536000,
        32'd68169600,   32'd68255999,   32'd68256000,   32'd946684799,
        32'd951782400,  32'd4102444799, 32'd4107542399, 32'd4107542400,
        32'h5555_5555,  32'hAAAA_AAAA,  32'h7FFF_FFFF,  32'h8000_0000
    };
    localparam int LATENCY_SLACK = 12;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    // shared pacing controls
    bit steady = 1'b0;
    int hold_off = 0;

    calendar_scoreboard sb;

    epoch_seconds_to_calendar_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever begin
            #10 aclk = ~aclk;
        end
    end

    // offer one request, idling at random first, and wait for it to be taken
    task send_request(input logic [31:0] secs);
        while (!steady && $urandom_range(99) < 13) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= secs;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        sb.note_request(secs);
    endtask

    task wait_drained();
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
    endtask

    // random count biased toward day boundaries, the century february end and the range ends
    function automatic logic [31:0] pick_secs();
        logic [63:0] wide;
        case ($urandom_range(9))
            4: begin
                // around the century year february end
                wide = 64'd4107542400 - 64'd300000 + $urandom_range(600000);
            end
            5: begin
                // first or last second of a random day
                wide = 64'd86400 * $urandom_range(49710);
                if ($urandom_range(1) == 1) begin
                    wide = wide + 64'd86399;
                end
                if (wide > 64'hFFFF_FFFF) begin
                    wide = 64'hFFFF_FFFF;
                end
            end
            6: begin
                wide = 64'hFFFF_FFFF - $urandom_range(40000000);
            end
            7: begin
                wide = {32'd0, $urandom_range(100000000)};
            end
            default: begin
                wide = {32'd0, $urandom};
            end
        endcase
        return wide[31:0];
    endfunction

    // result side: check accepted results, then pick the next ready
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
            end
            if (hold_off > 0) begin
                m_tready <= 1'b0;
                hold_off--;
            end else begin
                m_tready <= steady || ($urandom_range(99) >= 13);
            end
        end
    end

    // main sequence
    initial begin
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed boundaries
        for (int i = 0; i < CORNER_COUNT; i++) begin
            send_request(CORNER_SECS[i]);
        end

        // random with idling on both sides
        for (int i = 0; i < 550; i++) begin
            send_request(pick_secs());
        end

        // back to back with no idling
        steady = 1'b1;
        for (int i = 0; i < 300; i++) begin
            send_request(pick_secs());
        end
        steady = 1'b0;

        // long result stall while requests keep coming, so the pipe backs up
        hold_off = 80;
        for (int i = 0; i < 50; i++) begin
            send_request(pick_secs());
        end

        // pause until every request has its result
        s_tvalid <= 1'b0;
        wait_drained();
        @(posedge aclk);

        for (int i = 0; i < 530; i++) begin
            send_request(pick_secs());
        end
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (LATENCY_SLACK) @(posedge aclk);
        sb.flush_check();
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // hang guard
    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/esc_pkg.sv
hdl/esc_tod.sv
hdl/esc_date.sv
hdl/epoch_seconds_to_calendar_core.sv
hdl/esc_checker.sv
tb/tb_epoch_seconds_to_calendar_core.sv
